/* src/xec_pkg.sv */
`timescale 1ns / 1ps

package xec_pkg;

  // Most bytes one text byte can produce, and most bytes held after an ampersand.
  localparam int NUM_RES  = 6;
  localparam int HELD_MAX = 4;
  localparam int NUM_ENT  = 5;
  localparam int NAME_MAX = 5;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_QUOT = 8'h22;

  // Register index of the direction register (one address bit above the byte offset).
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic DIR_ESCAPE   = 1'b0;
  localparam logic DIR_UNESCAPE = 1'b1;

  typedef enum logic [2:0] {
    ENT_LT   = 3'd0,
    ENT_GT   = 3'd1,
    ENT_AMP  = 3'd2,
    ENT_APOS = 3'd3,
    ENT_QUOT = 3'd4
  } ent_t;

  typedef logic [NAME_MAX-1:0][7:0] name_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_end;
  } out_item_t;

  // All result bytes caused by one text byte; byte 0 goes out first.
  typedef struct packed {
    logic [NUM_RES-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    text_end;
  } job_t;

  function automatic logic [7:0] ent_raw(ent_t k);
    logic [7:0] r;
    unique case (k)
      ENT_LT:   r = CH_LT;
      ENT_GT:   r = CH_GT;
      ENT_AMP:  r = CH_AMP;
      ENT_APOS: r = CH_APOS;
      ENT_QUOT: r = CH_QUOT;
      default:  r = CH_AMP;
    endcase
    return r;
  endfunction

  // Entity name without the leading ampersand, first character in element 0.
  function automatic name_t ent_name(ent_t k);
    name_t r;
    r = '0;
    unique case (k)
      ENT_LT: begin
        r[0] = 8'h6C; r[1] = 8'h74; r[2] = 8'h3B;
      end
      ENT_GT: begin
        r[0] = 8'h67; r[1] = 8'h74; r[2] = 8'h3B;
      end
      ENT_AMP: begin
        r[0] = 8'h61; r[1] = 8'h6D; r[2] = 8'h70; r[3] = 8'h3B;
      end
      ENT_APOS: begin
        r[0] = 8'h61; r[1] = 8'h70; r[2] = 8'h6F; r[3] = 8'h73; r[4] = 8'h3B;
      end
      ENT_QUOT: begin
        r[0] = 8'h71; r[1] = 8'h75; r[2] = 8'h6F; r[3] = 8'h74; r[4] = 8'h3B;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ent_len(ent_t k);
    logic [2:0] r;
    unique case (k)
      ENT_LT, ENT_GT:     r = 3'd3;
      ENT_AMP:            r = 3'd4;
      ENT_APOS, ENT_QUOT: r = 3'd5;
      default:            r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

/* src/xec_front.sv */
`timescale 1ns / 1ps

module xec_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              dir,
  input  logic              clear,
  input  logic              accept,
  input  xec_pkg::in_item_t item,
  output xec_pkg::job_t     job,
  output logic              job_push
);

  logic [xec_pkg::HELD_MAX-1:0][7:0] held;
  logic [xec_pkg::HELD_MAX-1:0][7:0] held_next;
  logic [2:0]                        held_count;
  logic [2:0]                        held_count_next;
  logic                              amp_pending;
  logic                              amp_pending_next;

  logic [7:0]                        c;
  logic [xec_pkg::NAME_MAX-1:0][7:0] cand;
  logic [2:0]                        len;
  logic [2:0]                        n;
  logic                              enc_hit;
  xec_pkg::ent_t                     enc_k;
  logic                              hit;
  xec_pkg::ent_t                     hit_k;
  logic                              prefix;
  logic                              match;
  xec_pkg::name_t                    nm;

  always_comb begin
    c                = item.text_byte;
    job              = '0;
    n                = '0;
    held_next        = held;
    held_count_next  = held_count;
    amp_pending_next = amp_pending;
    enc_hit          = 1'b0;
    enc_k            = xec_pkg::ENT_LT;
    hit              = 1'b0;
    hit_k            = xec_pkg::ENT_LT;
    prefix           = 1'b0;
    match            = 1'b0;
    cand             = '0;
    len              = '0;
    nm               = '0;

    if (dir == xec_pkg::DIR_ESCAPE) begin
      for (int k = 0; k < xec_pkg::NUM_ENT; k++) begin
        if (c == xec_pkg::ent_raw(xec_pkg::ent_t'(3'(k)))) begin
          enc_hit = 1'b1;
          enc_k   = xec_pkg::ent_t'(3'(k));
        end
      end
      if (enc_hit) begin
        nm           = xec_pkg::ent_name(enc_k);
        job.bytes[0] = xec_pkg::CH_AMP;
        for (int i = 0; i < xec_pkg::NAME_MAX; i++) begin
          job.bytes[i+1] = nm[i];
        end
        n = 3'(xec_pkg::ent_len(enc_k) + 3'd1);
      end else begin
        job.bytes[0] = c;
        n            = 3'd1;
      end
    end else begin
      if (amp_pending) begin
        // Candidate name: the held bytes followed by the new byte.
        for (int i = 0; i < xec_pkg::HELD_MAX; i++) begin
          cand[i] = (3'(i) < held_count) ? held[i] : c;
        end
        cand[xec_pkg::HELD_MAX] = c;
        len = 3'(held_count + 3'd1);

        for (int k = 0; k < xec_pkg::NUM_ENT; k++) begin
          nm    = xec_pkg::ent_name(xec_pkg::ent_t'(3'(k)));
          match = (len <= xec_pkg::ent_len(xec_pkg::ent_t'(3'(k))));
          for (int i = 0; i < xec_pkg::NAME_MAX; i++) begin
            if (3'(i) < len && cand[i] != nm[i]) begin
              match = 1'b0;
            end
          end
          if (match) begin
            if (len == xec_pkg::ent_len(xec_pkg::ent_t'(3'(k)))) begin
              hit   = 1'b1;
              hit_k = xec_pkg::ent_t'(3'(k));
            end else begin
              prefix = 1'b1;
            end
          end
        end

        if (hit) begin
          job.bytes[0]     = xec_pkg::ent_raw(hit_k);
          n                = 3'd1;
          amp_pending_next = 1'b0;
          held_count_next  = '0;
        end else if (prefix && held_count < 3'(xec_pkg::HELD_MAX)) begin
          held_next[held_count[1:0]] = c;
          held_count_next            = 3'(held_count + 3'd1);
        end else begin
          // Mismatch: give back the ampersand and held bytes literally,
          // then treat the new byte as the start of fresh text.
          job.bytes[0] = xec_pkg::CH_AMP;
          for (int i = 0; i < xec_pkg::HELD_MAX; i++) begin
            if (3'(i) < held_count) begin
              job.bytes[i+1] = held[i];
            end
          end
          n                = 3'(held_count + 3'd1);
          amp_pending_next = 1'b0;
          held_count_next  = '0;
          if (c == xec_pkg::CH_AMP) begin
            amp_pending_next = 1'b1;
          end else begin
            job.bytes[n] = c;
            n            = 3'(n + 3'd1);
          end
        end
      end else begin
        if (c == xec_pkg::CH_AMP) begin
          amp_pending_next = 1'b1;
          held_count_next  = '0;
        end else begin
          job.bytes[0] = c;
          n            = 3'd1;
        end
      end

      // End of text flushes whatever is still held. Held bytes remain only
      // when nothing was emitted above, so they start right after the ampersand.
      if (item.text_end && amp_pending_next) begin
        job.bytes[n] = xec_pkg::CH_AMP;
        for (int i = 0; i < xec_pkg::HELD_MAX; i++) begin
          if (3'(i) < held_count_next) begin
            job.bytes[i+1] = held_next[i];
          end
        end
        n                = 3'(n + 3'd1 + held_count_next);
        amp_pending_next = 1'b0;
        held_count_next  = '0;
      end
    end

    job.count    = n;
    job.text_end = item.text_end;
  end

  assign job_push = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count  <= '0;
      amp_pending <= 1'b0;
    end else if (clear) begin
      held_count  <= '0;
      amp_pending <= 1'b0;
    end else if (accept) begin
      held_count  <= held_count_next;
      amp_pending <= amp_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

/* src/xec_job_fifo.sv */
`timescale 1ns / 1ps

module xec_job_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  xec_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output xec_pkg::job_t rd_job,
  output logic          rd_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xec_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (wr_en && !rd_en) begin
        count <= CW'(count + 1'b1);
      end else if (!wr_en && rd_en) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

/* src/xec_back.sv */
`timescale 1ns / 1ps

module xec_back (
  input  logic               clk,
  input  logic               rst,
  input  xec_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  output xec_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);

  logic [2:0]         idx;
  logic               out_valid;
  xec_pkg::out_item_t out_reg;
  logic               load;
  logic               is_last;

  assign empty   = !out_valid;
  assign result  = out_reg;
  assign load    = job_valid && (!out_valid || pop);
  assign is_last = (idx == 3'(job.count - 3'd1));
  assign job_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : 3'(idx + 3'd1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg.out_byte <= job.bytes[idx];
      out_reg.run_last <= is_last;
      out_reg.out_end  <= is_last && job.text_end;
    end
  end

endmodule

/* src/xml_entity_escape_codec.sv */
`timescale 1ns / 1ps
// An accepted byte goes from the front end into the job queue, then from the
// queue to the output register. Throughput: one result byte per cycle while
// popped; a text byte yields zero to six bytes, sent in turn by the output
// serializer. Synchronous active-high reset empties the job queue and output
// register, clears any held ampersand and resets direction to escape.

module xml_entity_escape_codec #(
  parameter int JOB_QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // Input text, one byte per transaction.
  input  logic               push,
  output logic               full,
  input  xec_pkg::in_item_t  item,
  // Converted text, one byte per transaction.
  output logic               empty,
  input  logic               pop,
  output xec_pkg::out_item_t result,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The direction register lives here. A write to it also drops any partially
  // matched entity in the front end, so decoding starts clean afterwards.
  logic          dir;
  logic          cfg_wr;
  logic          dir_wr;

  logic          accept;
  xec_pkg::job_t front_job;
  logic          front_push;
  xec_pkg::job_t head_job;
  logic          head_valid;
  logic          head_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign dir_wr = cfg_wr && (paddr[2] == xec_pkg::REG_DIRECTION);

  always_comb begin
    prdata = '0;
    if (paddr[2] == xec_pkg::REG_DIRECTION) begin
      prdata[0] = dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= xec_pkg::DIR_ESCAPE;
    end else if (dir_wr) begin
      dir <= pwdata[0];
    end
  end

  // The front end classifies each byte and builds, combinationally, the complete
  // list of bytes it causes; a byte that is only held pushes no job.
  assign accept = push && !full;

  xec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dir      (dir),
    .clear    (dir_wr),
    .accept   (accept),
    .item     (item),
    .job      (front_job),
    .job_push (front_push)
  );

  // Short job queue between classification and output; the front stalls
  // only when it is full.
  xec_job_fifo #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_push),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (head_pop),
    .rd_job   (head_job),
    .rd_valid (head_valid)
  );

  // The back end walks the head job one byte per cycle, while the output register
  // is empty or popped, into that register and marks the last byte of each job and the end of the text.
  xec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (head_valid),
    .job_pop   (head_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
